// File: hdl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define CHK_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// antecedent in one cycle implies consequent in the next
`define CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/phsc_pkg.sv
// package: widths, register indexes, multiplier request type and saturation helpers
package phsc_pkg;

    localparam int DATA_W    = 32;
    localparam int MUL_W     = 33;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int INT_W     = 18;
    localparam int ACC_W     = DATA_W + 2;
    localparam int FRAC_W    = 16;
    localparam int TP_W      = 16;
    localparam int TR_W      = 31;
    localparam int THR_W     = 31;
    localparam int CFG_IDX_W = 3;

    localparam logic signed [INT_W-1:0] INT_MAX = 18'sd65536;
    localparam logic signed [INT_W-1:0] INT_MIN = -18'sd65536;

    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_GAIN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADING_P_GAIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEADING_I_GAIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEADING_D_GAIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TICK_RATE          = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HEADING_THRESHOLD  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_THRESHOLD = 3'd7;

    typedef struct packed {
        logic                    en;
        logic signed [MUL_W-1:0] a;
        logic signed [MUL_W-1:0] b;
    } mul_req_t;

    // floor a q16.16 product by 16 bits and saturate to 32 bits
    function automatic logic signed [DATA_W-1:0] sat_q(input logic signed [PROD_W-1:0] p);
        logic [PROD_W-DATA_W-FRAC_W:0] hi;
        hi = p[PROD_W-1:DATA_W+FRAC_W-1];
        if ((&hi) || (~|hi))
            sat_q = p[DATA_W+FRAC_W-1:FRAC_W];
        else if (p[PROD_W-1])
            sat_q = Q_MIN;
        else
            sat_q = Q_MAX;
    endfunction

    // saturate a widened sum to 32 bits
    function automatic logic signed [DATA_W-1:0] sat_acc(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-DATA_W:0] hi;
        hi = v[ACC_W-1:DATA_W-1];
        if ((&hi) || (~|hi))
            sat_acc = v[DATA_W-1:0];
        else if (v[ACC_W-1])
            sat_acc = Q_MIN;
        else
            sat_acc = Q_MAX;
    endfunction

endpackage

// File: hdl/phsc_mul.sv
// shared signed multiplier with registered product
module phsc_mul
    import phsc_pkg::*;
(
    input  logic                     clk,
    input  mul_req_t                 req,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    always_comb
    begin
        prod_next = prod_reg;
        if (req.en)
        begin
            prod_next = req.a * req.b;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// File: hdl/pid_heading_speed_controller.sv
// top level: heading and speed pid controller with clamped heading integral
// an input beat steps through ST_INT to ST_F, then ST_FIN loads the output beat once the output is free
// the input takes no new beat before the last one is done; the one shared 33x33 multiplier
//   runs six products per item in sequence (e*dt, diff*rate, three pid terms, distance)
// a pending output beat that is not taken stalls the last step, and the input stays not ready
// reset (rst_n, async, active low) clears state and loads the default configuration
module pid_heading_speed_controller
    import phsc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // config write port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    // input beat
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [2*DATA_W-1:0]  s_axis_tdata,   // [31:0] distance_error, [63:32] heading_error
    // output beat
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [2*DATA_W-1:0]  m_axis_tdata    // [31:0] forward_command, [63:32] turn_command
);

`include "assert_macros.svh"

    // sequencer steps; each multiply step issues one product, and each step after ST_INT retires the previous one
    localparam logic [2:0] ST_IDLE = 3'd0;  // wait for an input beat
    localparam logic [2:0] ST_INT  = 3'd1;  // issue e*dt, form saturated error difference
    localparam logic [2:0] ST_DER  = 3'd2;  // issue diff*rate, update clamped integral
    localparam logic [2:0] ST_P    = 3'd3;  // issue kp*e, latch derivative
    localparam logic [2:0] ST_I    = 3'd4;  // issue ki*integral, start pid sum
    localparam logic [2:0] ST_D    = 3'd5;  // issue kd*deriv, add integral term
    localparam logic [2:0] ST_F    = 3'd6;  // issue kdist*dist, add derivative term
    localparam logic [2:0] ST_FIN  = 3'd7;  // pick the mode and load the output

    // configuration registers
    logic signed [DATA_W-1:0] dist_gain_reg, dist_gain_next;
    logic signed [DATA_W-1:0] p_gain_reg, p_gain_next;
    logic signed [DATA_W-1:0] i_gain_reg, i_gain_next;
    logic signed [DATA_W-1:0] d_gain_reg, d_gain_next;
    logic [TP_W-1:0]          tick_period_reg, tick_period_next;
    logic [TR_W-1:0]          tick_rate_reg, tick_rate_next;
    logic [THR_W-1:0]         head_thr_reg, head_thr_next;
    logic [THR_W-1:0]         dist_thr_reg, dist_thr_next;

    // control
    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    // controller state
    logic signed [DATA_W-1:0] last_err_reg, last_err_next;
    logic signed [INT_W-1:0]  integral_reg, integral_next;
    logic                     yaw_fix_reg, yaw_fix_next;
    logic signed [DATA_W-1:0] held_fwd_reg, held_fwd_next;
    logic signed [DATA_W-1:0] held_turn_reg, held_turn_next;

    // per-item working registers
    logic signed [DATA_W-1:0] dist_reg, dist_next;
    logic signed [DATA_W-1:0] head_reg, head_next;
    logic signed [DATA_W-1:0] diff_reg, diff_next;
    logic signed [DATA_W-1:0] deriv_reg, deriv_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;

    // shared multiplier
    mul_req_t                 mul_req;
    logic signed [PROD_W-1:0] prod;

    phsc_mul u_mul (
        .clk  (clk),
        .req  (mul_req),
        .prod (prod)
    );

    logic signed [DATA_W-1:0] term_q;      // floored and saturated product
    logic signed [DATA_W:0]   diff_wide;
    logic signed [DATA_W:0]   int_sum;
    logic signed [DATA_W-1:0] pid;
    logic [DATA_W-1:0]        head_abs;
    logic                     turn_needed;
    logic                     dist_far;
    logic                     out_free;

    assign term_q = sat_q(prod);
    assign diff_wide = {head_reg[DATA_W-1], head_reg} - {last_err_reg[DATA_W-1], last_err_reg};
    // e*dt fits 48 bits, so its floor fits 32 without saturation
    assign int_sum = {{(DATA_W+1-INT_W){integral_reg[INT_W-1]}}, integral_reg}
                   + {prod[DATA_W+FRAC_W-1], prod[DATA_W+FRAC_W-1:FRAC_W]};
    assign pid = sat_acc(acc_reg);
    // magnitude as unsigned, so the most negative error maps to 2^31
    assign head_abs = head_reg[DATA_W-1] ? DATA_W'(-head_reg) : DATA_W'(head_reg);
    assign turn_needed = head_abs > {1'b0, head_thr_reg};
    assign dist_far = dist_reg > $signed({1'b0, dist_thr_reg});
    assign out_free = !out_valid_reg || m_axis_tready;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {held_turn_reg, held_fwd_reg};

    // operand select for the shared multiplier
    always_comb
    begin
        mul_req.en = 1'b1;
        mul_req.a  = '0;
        mul_req.b  = '0;
        case (state_reg)
            ST_INT:
            begin
                mul_req.a = {head_reg[DATA_W-1], head_reg};
                mul_req.b = {{(MUL_W-TP_W){1'b0}}, tick_period_reg};
            end
            ST_DER:
            begin
                mul_req.a = {diff_reg[DATA_W-1], diff_reg};
                mul_req.b = {{(MUL_W-TR_W){1'b0}}, tick_rate_reg};
            end
            ST_P:
            begin
                mul_req.a = {p_gain_reg[DATA_W-1], p_gain_reg};
                mul_req.b = {head_reg[DATA_W-1], head_reg};
            end
            ST_I:
            begin
                mul_req.a = {i_gain_reg[DATA_W-1], i_gain_reg};
                mul_req.b = {{(MUL_W-INT_W){integral_reg[INT_W-1]}}, integral_reg};
            end
            ST_D:
            begin
                mul_req.a = {d_gain_reg[DATA_W-1], d_gain_reg};
                mul_req.b = {deriv_reg[DATA_W-1], deriv_reg};
            end
            ST_F:
            begin
                mul_req.a = {dist_gain_reg[DATA_W-1], dist_gain_reg};
                mul_req.b = {dist_reg[DATA_W-1], dist_reg};
            end
            default:
            begin
                mul_req.en = 1'b0;
            end
        endcase
    end

    // configuration writes
    always_comb
    begin
        dist_gain_next   = dist_gain_reg;
        p_gain_next      = p_gain_reg;
        i_gain_next      = i_gain_reg;
        d_gain_next      = d_gain_reg;
        tick_period_next = tick_period_reg;
        tick_rate_next   = tick_rate_reg;
        head_thr_next    = head_thr_reg;
        dist_thr_next    = dist_thr_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_DISTANCE_GAIN:      dist_gain_next   = cfg_data;
                REG_HEADING_P_GAIN:     p_gain_next      = cfg_data;
                REG_HEADING_I_GAIN:     i_gain_next      = cfg_data;
                REG_HEADING_D_GAIN:     d_gain_next      = cfg_data;
                REG_TICK_PERIOD:        tick_period_next = cfg_data[TP_W-1:0];
                REG_TICK_RATE:          tick_rate_next   = cfg_data[TR_W-1:0];
                REG_HEADING_THRESHOLD:  head_thr_next    = cfg_data[THR_W-1:0];
                REG_DISTANCE_THRESHOLD: dist_thr_next    = cfg_data[THR_W-1:0];
                default:                ;
            endcase
        end
    end

    // sequencer and datapath
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        last_err_next  = last_err_reg;
        integral_next  = integral_reg;
        yaw_fix_next   = yaw_fix_reg;
        held_fwd_next  = held_fwd_reg;
        held_turn_next = held_turn_reg;
        dist_next      = dist_reg;
        head_next      = head_reg;
        diff_next      = diff_reg;
        deriv_next     = deriv_reg;
        acc_next       = acc_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    dist_next  = s_axis_tdata[DATA_W-1:0];
                    head_next  = s_axis_tdata[2*DATA_W-1:DATA_W];
                    state_next = ST_INT;
                end
            end
            ST_INT:
            begin
                diff_next  = sat_acc({diff_wide[DATA_W], diff_wide});
                state_next = ST_DER;
            end
            ST_DER:
            begin
                // clamp to plus or minus 1.0
                if (int_sum > $signed({{(DATA_W+1-INT_W){1'b0}}, INT_MAX}))
                    integral_next = INT_MAX;
                else if (int_sum < $signed({{(DATA_W+1-INT_W){1'b1}}, INT_MIN}))
                    integral_next = INT_MIN;
                else
                    integral_next = int_sum[INT_W-1:0];
                state_next = ST_P;
            end
            ST_P:
            begin
                deriv_next = term_q;
                state_next = ST_I;
            end
            ST_I:
            begin
                acc_next   = {{(ACC_W-DATA_W){term_q[DATA_W-1]}}, term_q};
                state_next = ST_D;
            end
            ST_D:
            begin
                acc_next   = acc_reg + {{(ACC_W-DATA_W){term_q[DATA_W-1]}}, term_q};
                state_next = ST_F;
            end
            ST_F:
            begin
                acc_next   = acc_reg + {{(ACC_W-DATA_W){term_q[DATA_W-1]}}, term_q};
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // the product register still holds kdist*dist until the next item
                if (out_free)
                begin
                    last_err_next  = head_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    if (turn_needed && !yaw_fix_reg)
                    begin
                        held_fwd_next  = '0;
                        held_turn_next = pid;
                    end
                    else if (dist_far)
                    begin
                        held_fwd_next  = term_q;
                        held_turn_next = pid;
                    end
                    else if (turn_needed)
                    begin
                        // sticky until reset
                        yaw_fix_next   = 1'b1;
                        held_fwd_next  = '0;
                        held_turn_next = pid;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_gain_reg   <= '0;
            p_gain_reg      <= '0;
            i_gain_reg      <= '0;
            d_gain_reg      <= '0;
            tick_period_reg <= TP_W'(6554);
            tick_rate_reg   <= TR_W'(655360);
            head_thr_reg    <= THR_W'(3277);
            dist_thr_reg    <= THR_W'(3277);
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            last_err_reg    <= '0;
            integral_reg    <= '0;
            yaw_fix_reg     <= 1'b0;
            held_fwd_reg    <= '0;
            held_turn_reg   <= '0;
        end
        else
        begin
            dist_gain_reg   <= dist_gain_next;
            p_gain_reg      <= p_gain_next;
            i_gain_reg      <= i_gain_next;
            d_gain_reg      <= d_gain_next;
            tick_period_reg <= tick_period_next;
            tick_rate_reg   <= tick_rate_next;
            head_thr_reg    <= head_thr_next;
            dist_thr_reg    <= dist_thr_next;
            state_reg       <= state_next;
            out_valid_reg   <= out_valid_next;
            last_err_reg    <= last_err_next;
            integral_reg    <= integral_next;
            yaw_fix_reg     <= yaw_fix_next;
            held_fwd_reg    <= held_fwd_next;
            held_turn_reg   <= held_turn_next;
        end
    end

    // working registers need no reset
    always_ff @(posedge clk)
    begin
        dist_reg  <= dist_next;
        head_reg  <= head_next;
        diff_reg  <= diff_next;
        deriv_reg <= deriv_next;
        acc_reg   <= acc_next;
    end

    // heading integral never leaves plus or minus 1.0
    `CHK_ALWAYS(a_integral_range, integral_reg <= INT_MAX && integral_reg >= INT_MIN, "heading integral out of range")

    // yaw-fix flag only clears on reset
    `CHK_NEXT(a_yaw_fix_sticky, yaw_fix_reg, yaw_fix_reg, "yaw fix flag dropped")

    // a waiting output beat holds the last step and its commands
    `CHK_NEXT(a_fin_stall, state_reg == ST_FIN && out_valid_reg && !m_axis_tready, state_reg == ST_FIN && $stable(held_turn_reg) && $stable(held_fwd_reg), "output overwritten while pending")

endmodule

// File: test/pid_heading_speed_controller_test.sv
// self-checking stream testbench for the heading and speed pid controller
`timescale 1ns / 1ps

module pid_heading_speed_controller_test;
    import phsc_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_PHASES  = 6;
    localparam int HALF_PHASE     = 150;

    // one input beat: distance in the low word, heading in the high word
    typedef struct packed {
        logic signed [DATA_W-1:0] heading;
        logic signed [DATA_W-1:0] distance;
    } steer_item_t;

    // one output beat: forward in the low word, turn in the high word
    typedef struct packed {
        logic signed [DATA_W-1:0] turn;
        logic signed [DATA_W-1:0] forward;
    } command_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0]    cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [2*DATA_W-1:0]  s_axis_tdata = '0;   // [31:0] distance_error, [63:32] heading_error
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [2*DATA_W-1:0]  m_axis_tdata;         // [31:0] forward_command, [63:32] turn_command

    pid_heading_speed_controller u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    // shadow of the configuration registers, reset values
    logic signed [DATA_W-1:0] fwd_gain  = '0;
    logic signed [DATA_W-1:0] hdg_kp    = '0;
    logic signed [DATA_W-1:0] hdg_ki    = '0;
    logic signed [DATA_W-1:0] hdg_kd    = '0;
    logic [TP_W-1:0]          dt_q16    = 16'd6554;
    logic [TR_W-1:0]          rate_q16  = 31'd655360;
    logic [THR_W-1:0]         hdg_limit = 31'd3277;
    logic [THR_W-1:0]         dist_limit = 31'd3277;

    // shadow of the controller state
    logic signed [DATA_W-1:0] prev_heading = '0;
    logic signed [INT_W-1:0]  hdg_integral = '0;
    logic                     yaw_fix      = 1'b0;
    logic signed [DATA_W-1:0] hold_forward = '0;
    logic signed [DATA_W-1:0] hold_turn    = '0;

    steer_item_t pending_items[$];
    command_t    expected_commands[$];

    logic gaps_on = 1'b1;
    int   beats_in = 0;
    int   beats_out = 0;
    int   cfg_writes = 0;
    int   mismatch_count = 0;
    int   idle_cycles = 0;
    int   n_turn_in_place = 0;
    int   n_drive_turn = 0;
    int   n_flagged = 0;
    int   n_held = 0;

    function automatic longint sat_word(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // q16.16 product, floored by the arithmetic shift, then saturated
    function automatic longint fixed_mul(input longint a, input longint b);
        return sat_word((a * b) >>> 16);
    endfunction

    // advance the shadow controller by one tick and return the commands it emits
    function automatic command_t step_controller(input steer_item_t it);
        longint   dist_err;
        longint   err;
        longint   integ;
        longint   diff;
        longint   deriv;
        longint   pid;
        logic     turn_needed;
        command_t res;
        dist_err = longint'(it.distance);
        err      = longint'(it.heading);

        // integral of e*dt, clamped to plus or minus one
        integ = longint'(hdg_integral) + ((err * longint'(dt_q16)) >>> 16);
        if (integ > 64'sd65536)
            integ = 64'sd65536;
        if (integ < -64'sd65536)
            integ = -64'sd65536;
        hdg_integral = integ[INT_W-1:0];

        // derivative uses the previous error before it is replaced
        diff  = sat_word(err - longint'(prev_heading));
        deriv = fixed_mul(diff, longint'(rate_q16));
        prev_heading = it.heading;

        pid = sat_word(fixed_mul(longint'(hdg_kp), err)
                     + fixed_mul(longint'(hdg_ki), longint'(hdg_integral))
                     + fixed_mul(longint'(hdg_kd), deriv));

        turn_needed = ((err < 0) ? -err : err) > longint'(hdg_limit);
        if (turn_needed && !yaw_fix)
        begin
            hold_forward = '0;
            hold_turn    = pid[DATA_W-1:0];
            n_turn_in_place++;
        end
        else if (dist_err > longint'(dist_limit))
        begin
            hold_forward = DATA_W'(fixed_mul(longint'(fwd_gain), dist_err));
            hold_turn    = pid[DATA_W-1:0];
            n_drive_turn++;
        end
        else if (turn_needed)
        begin
            yaw_fix      = 1'b1;
            hold_forward = '0;
            hold_turn    = pid[DATA_W-1:0];
            n_flagged++;
        end
        else
        begin
            // no mode applies, last commands stay
            n_held++;
        end

        res.forward = hold_forward;
        res.turn    = hold_turn;
        return res;
    endfunction

    // sender: valid stays up until the beat is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_commands.push_back(step_controller(steer_item_t'(s_axis_tdata)));
                beats_in++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_items.size() > 0 && !(gaps_on && $urandom_range(99) < 15))
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pending_items.pop_front();
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls, compares each taken beat with the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= !(gaps_on && $urandom_range(99) < 15);
            if (m_axis_tvalid && m_axis_tready)
            begin
                command_t got;
                command_t want;
                got = command_t'(m_axis_tdata);
                beats_out++;
                if (expected_commands.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected output beat: forward %h turn %h",
                                 got.forward, got.turn);
                end
                else
                begin
                    want = expected_commands.pop_front();
                    if (got.forward !== want.forward || got.turn !== want.turn)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("beat %0d mismatch: forward exp %h got %h, turn exp %h got %h",
                                     beats_out, want.forward, got.forward, want.turn, got.turn);
                    end
                end
            end
        end
    end

    // watchdog: cycles with no beat on either side and no register write while work is outstanding
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || cfg_we
            || (pending_items.size() == 0 && expected_commands.size() == 0 && !s_axis_tvalid))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no beat for %0d cycles, %0d results outstanding",
                     idle_cycles, expected_commands.size());
            $display("TB_ERROR");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // block until every queued beat is taken and every result is back
    task automatic wait_until_settled();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || s_axis_tvalid || expected_commands.size() != 0);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_DISTANCE_GAIN:      fwd_gain   = value;
            REG_HEADING_P_GAIN:     hdg_kp     = value;
            REG_HEADING_I_GAIN:     hdg_ki     = value;
            REG_HEADING_D_GAIN:     hdg_kd     = value;
            REG_TICK_PERIOD:        dt_q16     = value[TP_W-1:0];
            REG_TICK_RATE:          rate_q16   = value[TR_W-1:0];
            REG_HEADING_THRESHOLD:  hdg_limit  = value[THR_W-1:0];
            REG_DISTANCE_THRESHOLD: dist_limit = value[THR_W-1:0];
            default: ;
        endcase
        cfg_writes++;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic load_settings(input logic [DATA_W-1:0] fg, input logic [DATA_W-1:0] kp,
                                 input logic [DATA_W-1:0] ki, input logic [DATA_W-1:0] kd,
                                 input logic [TP_W-1:0] dt, input logic [TR_W-1:0] rate,
                                 input logic [THR_W-1:0] hthr, input logic [THR_W-1:0] dthr);
        write_register(REG_DISTANCE_GAIN, fg);
        write_register(REG_HEADING_P_GAIN, kp);
        write_register(REG_HEADING_I_GAIN, ki);
        write_register(REG_HEADING_D_GAIN, kd);
        write_register(REG_TICK_PERIOD, {16'd0, dt});
        write_register(REG_TICK_RATE, {1'b0, rate});
        write_register(REG_HEADING_THRESHOLD, {1'b0, hthr});
        write_register(REG_DISTANCE_THRESHOLD, {1'b0, dthr});
    endtask

    // mostly gains within plus or minus 8.0, sometimes anything
    function automatic logic [DATA_W-1:0] rand_gain();
        if ($urandom_range(3) == 0)
            return $urandom;
        return DATA_W'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
    endfunction

    function automatic logic [THR_W-1:0] rand_limit();
        if ($urandom_range(4) == 0)
            return THR_W'($urandom >> 1);
        return THR_W'($urandom_range(0, 1 << 17));
    endfunction

    // operand clustered around the threshold so that the modes keep changing
    function automatic logic signed [DATA_W-1:0] rand_operand(input logic [THR_W-1:0] limit);
        longint span;
        longint v;
        span = (limit < 31'd1048576) ? longint'(limit) * 4 + 64 : 64'sd4194304;
        case ($urandom_range(9))
            0, 1, 2, 3: v = longint'($urandom_range(0, 32'(2 * span))) - span;
            4, 5:       v = longint'($urandom);
            6:
            begin
                case ($urandom_range(4))
                    0:       v = 64'sd2147483647;
                    1:       v = -64'sd2147483648;
                    2:       v = 0;
                    3:       v = 1;
                    default: v = -1;
                endcase
            end
            7, 8:
            begin
                // right at the threshold, either sign
                v = longint'(limit) + longint'($urandom_range(0, 2)) - 1;
                if ($urandom_range(1) == 1)
                    v = -v;
            end
            default: v = longint'($urandom_range(0, 128)) - 64;
        endcase
        return v[DATA_W-1:0];
    endfunction

    task automatic queue_random(input int count);
        steer_item_t it;
        for (int i = 0; i < count; i++)
        begin
            it.distance = rand_operand(dist_limit);
            it.heading  = rand_operand(hdg_limit);
            pending_items.push_back(it);
        end
    endtask

    task automatic queue_directed();
        // thresholds are at 3277 here: hold, drive edge, turn edge, saturation
        logic signed [DATA_W-1:0] dists[12];
        logic signed [DATA_W-1:0] heads[12];
        steer_item_t it;
        dists = '{32'sd0, Q_MAX, Q_MIN, 32'sd3277, 32'sd3278, 32'sd0,
                  32'sd0, 32'sd0, 32'sd0, 32'sd0, Q_MAX, 32'sd1};
        heads = '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd3277,
                  32'sd3278, -32'sd3278, Q_MAX, Q_MIN, Q_MIN, -32'sd1};
        for (int i = 0; i < 12; i++)
        begin
            it.distance = dists[i];
            it.heading  = heads[i];
            pending_items.push_back(it);
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed beats on the reset configuration, then on explicit gains
        queue_directed();
        wait_until_settled();
        load_settings(Q_MAX, Q_MIN, 32'h0001_0000, 32'hffff_8000,
                      16'hffff, 31'd65536, 31'd3277, 31'd3277);
        queue_directed();
        wait_until_settled();

        // random phases; phase 1 and 2 put every register at an extreme
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                1: load_settings(Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                                 16'hffff, 31'h7fff_ffff, 31'd0, 31'd0);
                2: load_settings(Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                                 16'd0, 31'd0, 31'h7fff_ffff, 31'h7fff_ffff);
                default:
                    load_settings(rand_gain(), rand_gain(), rand_gain(), rand_gain(),
                                  TP_W'($urandom_range(0, 65535)),
                                  ($urandom_range(1) == 1) ? TR_W'($urandom >> 1)
                                                           : TR_W'($urandom_range(0, 1 << 22)),
                                  rand_limit(), rand_limit());
            endcase
            // one phase runs without random gaps on either side
            gaps_on = (phase != 3);
            queue_random(HALF_PHASE);
            // sender holds off mid-phase until the pipe is empty
            wait_until_settled();
            queue_random(HALF_PHASE);
            wait_until_settled();
        end

        gaps_on = 1'b0;
        repeat (20) @(posedge clk);
        if (expected_commands.size() != 0)
            mismatch_count++;

        $display("covered %0d input beats, %0d output beats, %0d register writes",
                 beats_in, beats_out, cfg_writes);
        $display("modes: turn in place %0d, drive and turn %0d, flagged turn %0d, held %0d",
                 n_turn_in_place, n_drive_turn, n_flagged, n_held);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
